@@ design/dwmf_pkg.sv @@
`timescale 1ns / 1ps

package dwmf_pkg;

   // Sizes
   localparam int MaxWindow     = 16;
   localparam int MaxLine       = 4096;
   localparam int ByteWidth     = 8;
   localparam int WinLenWidth   = 5;
   localparam int PosWidth      = 13;
   localparam int FillWidth     = $clog2(MaxWindow + 1);
   localparam int CellIdxWidth  = $clog2(MaxWindow);
   localparam int LineCntWidth  = $clog2(MaxLine + 1);

   localparam logic [WinLenWidth-1:0] WinLenReset = WinLenWidth'(4);

   // Line terminators
   localparam logic [ByteWidth-1:0] TermNewline = 8'h0A;
   localparam logic [ByteWidth-1:0] TermNul     = 8'h00;

   // Controller states
   typedef enum logic {
      ST_SEARCH,
      ST_SKIP
   } state_type;

   // Controller -> datapath
   typedef struct packed {
      logic shift;       // take the byte into the run
      logic clear_line;  // terminator: empty run, zero line count
      logic emit;        // load the result register
      logic emit_found;  // result is a find
   } cmd_type;

   // Datapath -> controller
   typedef struct packed {
      logic is_term;     // byte is newline or NUL
      logic overrun;     // line already holds MaxLine bytes
      logic hit;         // run reaches the window after this byte
   } status_type;

endpackage

@@ design/dwmf_req_if.sv @@
`timescale 1ns / 1ps

interface dwmf_req_if;
   logic                              valid;
   logic                              ready;
   logic [dwmf_pkg::ByteWidth-1:0]    data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink   (input valid, input data_byte, output ready);
endinterface

@@ design/dwmf_rsp_if.sv @@
`timescale 1ns / 1ps

interface dwmf_rsp_if;
   logic                              valid;
   logic                              ready;
   logic                              found;
   logic [dwmf_pkg::PosWidth-1:0]     position;

   modport source (output valid, output found, output position, input ready);
   modport sink   (input valid, input found, input position, output ready);
endinterface

@@ design/dwmf_datapath.sv @@
`timescale 1ns / 1ps

module dwmf_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [dwmf_pkg::ByteWidth-1:0]      data_byte,
   input  logic                                csr_we,
   input  logic [dwmf_pkg::WinLenWidth-1:0]    csr_wdata,
   input  dwmf_pkg::cmd_type                   cmd,
   output dwmf_pkg::status_type                status,
   output logic                                found,
   output logic [dwmf_pkg::PosWidth-1:0]       position
);

   // Run of distinct bytes, newest in cell 0
   logic [dwmf_pkg::ByteWidth-1:0]    cell_ff [dwmf_pkg::MaxWindow];
   logic [dwmf_pkg::FillWidth-1:0]    fill_ff;
   logic [dwmf_pkg::FillWidth-1:0]    fill_in;
   logic [dwmf_pkg::LineCntWidth-1:0] count_ff;
   logic [dwmf_pkg::LineCntWidth-1:0] count_in;
   logic [dwmf_pkg::WinLenWidth-1:0]  win_len_ff;
   logic                              found_ff;
   logic [dwmf_pkg::PosWidth-1:0]     pos_ff;

   logic                              match_any;
   logic [dwmf_pkg::CellIdxWidth-1:0] match_idx;
   logic [dwmf_pkg::FillWidth-1:0]    need;

   // Compare the new byte with every live cell; at most one can match
   always_comb begin
      match_any = 1'b0;
      match_idx = '0;
      for (int j = dwmf_pkg::MaxWindow - 1; j >= 0; j--) begin
         if ((dwmf_pkg::FillWidth'(j) < fill_ff) && (cell_ff[j] == data_byte)) begin
            match_any = 1'b1;
            match_idx = dwmf_pkg::CellIdxWidth'(j);
         end
      end
   end

   // Run length after the byte: a repeat keeps only the newer cells
   always_comb begin
      if (match_any) begin
         fill_in = dwmf_pkg::FillWidth'(match_idx) + dwmf_pkg::FillWidth'(1);
      end else if (fill_ff >= dwmf_pkg::FillWidth'(dwmf_pkg::MaxWindow)) begin
         fill_in = dwmf_pkg::FillWidth'(dwmf_pkg::MaxWindow);
      end else begin
         fill_in = fill_ff + dwmf_pkg::FillWidth'(1);
      end
   end

   // Effective window: zero acts as one, clamp at the cell count
   always_comb begin
      if (win_len_ff == '0) begin
         need = dwmf_pkg::FillWidth'(1);
      end else if (dwmf_pkg::FillWidth'(win_len_ff) > dwmf_pkg::FillWidth'(dwmf_pkg::MaxWindow)) begin
         need = dwmf_pkg::FillWidth'(dwmf_pkg::MaxWindow);
      end else begin
         need = dwmf_pkg::FillWidth'(win_len_ff);
      end
   end

   assign count_in       = count_ff + dwmf_pkg::LineCntWidth'(1);
   assign status.is_term = (data_byte == dwmf_pkg::TermNewline) ||
                           (data_byte == dwmf_pkg::TermNul);
   assign status.overrun = (count_ff >= dwmf_pkg::LineCntWidth'(dwmf_pkg::MaxLine));
   assign status.hit     = (fill_in >= need);

   // Shift line
   always_ff @(posedge clock) begin
      if (cmd.shift) begin
         cell_ff[0] <= data_byte;
         for (int j = 1; j < dwmf_pkg::MaxWindow; j++) begin
            cell_ff[j] <= cell_ff[j-1];
         end
      end
   end

   // Line state
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff  <= '0;
         count_ff <= '0;
      end else if (cmd.clear_line) begin
         fill_ff  <= '0;
         count_ff <= '0;
      end else if (cmd.shift) begin
         fill_ff  <= fill_in;
         count_ff <= count_in;
      end
   end

   // Window length register
   always_ff @(posedge clock) begin
      if (reset) begin
         win_len_ff <= dwmf_pkg::WinLenReset;
      end else if (csr_we) begin
         win_len_ff <= csr_wdata;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         found_ff <= cmd.emit_found;
         pos_ff   <= cmd.emit_found ? count_in[dwmf_pkg::PosWidth-1:0] : '0;
      end
   end

   assign found    = found_ff;
   assign position = pos_ff;

endmodule

@@ design/dwmf_ctrl.sv @@
`timescale 1ns / 1ps

module dwmf_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  dwmf_pkg::status_type  status,
   output dwmf_pkg::cmd_type     cmd
);

   dwmf_pkg::state_type state_ff;
   dwmf_pkg::state_type state_in;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic                take;

   // One result register: take a byte unless it is full and not drained
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign take      = req_valid && req_ready;

   // Next state
   always_comb begin
      state_in = state_ff;
      if (take) begin
         unique case (state_ff)
            dwmf_pkg::ST_SEARCH: begin
               if (status.is_term) begin
                  state_in = dwmf_pkg::ST_SEARCH;
               end else if (status.overrun || status.hit) begin
                  state_in = dwmf_pkg::ST_SKIP;
               end
            end
            dwmf_pkg::ST_SKIP: begin
               if (status.is_term) begin
                  state_in = dwmf_pkg::ST_SEARCH;
               end
            end
            default: state_in = dwmf_pkg::ST_SEARCH;
         endcase
      end
   end

   // Commands
   always_comb begin
      cmd = '0;
      if (take) begin
         cmd.clear_line = status.is_term;
         unique case (state_ff)
            dwmf_pkg::ST_SEARCH: begin
               if (status.is_term || status.overrun) begin
                  cmd.emit = 1'b1;
               end else begin
                  cmd.shift      = 1'b1;
                  cmd.emit       = status.hit;
                  cmd.emit_found = status.hit;
               end
            end
            dwmf_pkg::ST_SKIP: begin
               cmd.shift = 1'b0;
            end
            default: cmd.emit = 1'b0;
         endcase
      end
   end

   // Result valid: set on a new result, cleared when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dwmf_pkg::ST_SEARCH;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

@@ design/distinct_window_marker_finder_core.sv @@
`timescale 1ns / 1ps

// Channel  Dir  Item contents
// req_ch   in   data_byte[7:0]
// rsp_ch   out  found, position[12:0]
// csr_*    in   csr_we, csr_wdata[4:0] (window length)
//
// One byte is taken per cycle unless req_ch stalls; its result, if any,
// shows on rsp_ch the next cycle from a single result register.
// The run compare checks all 16 cells at once against the new byte.
// A waiting result stalls req_ch only if rsp_ch is not taking it.
// Reset is synchronous, active high; window length returns to 4.

module distinct_window_marker_finder_core (
   input  logic                               clock,
   input  logic                               reset,
   dwmf_req_if.sink                           req_ch,
   dwmf_rsp_if.source                         rsp_ch,
   input  logic                               csr_we,
   input  logic [dwmf_pkg::WinLenWidth-1:0]   csr_wdata
);

   dwmf_pkg::cmd_type    cmd;
   dwmf_pkg::status_type status;
   logic                 req_ready;
   logic                 rsp_valid;
   logic                 found;
   logic [dwmf_pkg::PosWidth-1:0] position;

   // Sequencer
   dwmf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Run, counters and result
   dwmf_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .data_byte (req_ch.data_byte),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .status    (status),
      .found     (found),
      .position  (position)
   );

   assign req_ch.ready    = req_ready;
   assign rsp_ch.valid    = rsp_valid;
   assign rsp_ch.found    = found;
   assign rsp_ch.position = position;

endmodule

@@ test/tb_distinct_window_marker_finder_core.sv @@
`timescale 1ns / 1ps

module tb_distinct_window_marker_finder_core;

   // One result item: found flag and 1-based position
   typedef struct packed {
      logic                          found;
      logic [dwmf_pkg::PosWidth-1:0] position;
   } marker_result_type;

   // Marker search predictor plus queue of expected result items
   class marker_scoreboard;
      logic [dwmf_pkg::WinLenWidth-1:0] win_len;
      logic [dwmf_pkg::ByteWidth-1:0]   run_cells [dwmf_pkg::MaxWindow];
      int unsigned                      run_fill;
      int unsigned                      line_bytes;
      bit                               skipping;
      marker_result_type                expected_q[$];
      int unsigned                      errors;
      int unsigned                      checked;
      int unsigned                      taken;   // bytes that were not skipped

      function new();
         win_len    = dwmf_pkg::WinLenReset;
         run_fill   = 0;
         line_bytes = 0;
         skipping   = 0;
         errors     = 0;
         checked    = 0;
         taken      = 0;
      endfunction

      function void set_window(logic [dwmf_pkg::WinLenWidth-1:0] v);
         win_len = v;
      endfunction

      // Zero acts as one, anything past the cell count acts as the cell count
      function int unsigned effective_window();
         if (win_len == 0) return 1;
         if (win_len > dwmf_pkg::MaxWindow) return dwmf_pkg::MaxWindow;
         return win_len;
      endfunction

      function int unsigned pending();
         return expected_q.size();
      endfunction

      function void note_byte(logic [dwmf_pkg::ByteWidth-1:0] b);
         int                k;
         int                hit;
         marker_result_type r;
         // terminator: report failure unless already skipping, then new line
         if (b == dwmf_pkg::TermNewline || b == dwmf_pkg::TermNul) begin
            if (!skipping) begin
               r.found    = 1'b0;
               r.position = '0;
               expected_q.push_back(r);
            end
            taken++;
            run_fill   = 0;
            line_bytes = 0;
            skipping   = 0;
            return;
         end
         if (skipping) return;
         taken++;
         // line overrun
         if (line_bytes >= dwmf_pkg::MaxLine) begin
            skipping   = 1;
            r.found    = 1'b0;
            r.position = '0;
            expected_q.push_back(r);
            return;
         end
         line_bytes++;
         // repeat: drop everything up to and including the earlier copy
         hit = -1;
         for (k = 0; k < run_fill; k++) begin
            if (run_cells[k] == b) begin
               hit = k;
               break;
            end
         end
         if (hit >= 0) begin
            for (k = hit + 1; k < run_fill; k++) run_cells[k - hit - 1] = run_cells[k];
            run_fill -= hit + 1;
         end
         // run never fills up while searching, since the window is clamped
         run_cells[run_fill] = b;
         run_fill++;
         if (run_fill >= effective_window()) begin
            skipping   = 1;
            r.found    = 1'b1;
            r.position = dwmf_pkg::PosWidth'(line_bytes);
            expected_q.push_back(r);
         end
      endfunction

      function void check_result(logic f, logic [dwmf_pkg::PosWidth-1:0] p);
         marker_result_type e;
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected result item found=%0d position=%0d", $time, f, p);
            errors++;
            return;
         end
         e = expected_q.pop_front();
         checked++;
         if (f !== e.found) begin
            $display("%0t: found mismatch: expected %0d, actual %0d", $time, e.found, f);
            errors++;
         end
         if (p !== e.position) begin
            $display("%0t: position mismatch: expected %0d, actual %0d",
                     $time, e.position, p);
            errors++;
         end
      endfunction
   endclass

   logic                             clock;
   logic                             reset;
   logic                             csr_we;
   logic [dwmf_pkg::WinLenWidth-1:0] csr_wdata;
   bit                               steady;   // no random idling on either side
   marker_scoreboard                 sb;

   dwmf_req_if req_if();
   dwmf_rsp_if rsp_if();

   distinct_window_marker_finder_core uut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_if),
      .rsp_ch    (rsp_if),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Run limit
   initial begin
      #30_000_000;
      $display("distinct_window_marker_finder_core verification failed");
      $finish;
   end

   // Result monitor
   always @(posedge clock) begin
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
         sb.check_result(rsp_if.found, rsp_if.position);
   end

   // Result receiver: random stalls, one long hold-off once results flow
   initial begin : rsp_sink
      int unsigned hold_left;
      bit          long_done;
      int unsigned r;
      hold_left = 0;
      long_done = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (reset) begin
            rsp_if.ready <= 1'b0;
         end else if (hold_left > 0) begin
            rsp_if.ready <= 1'b0;
            hold_left--;
         end else if (!long_done && sb.checked >= 60) begin
            long_done = 1;
            hold_left = 300;
            rsp_if.ready <= 1'b0;
         end else if (steady) begin
            rsp_if.ready <= 1'b1;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
               rsp_if.ready <= 1'b1;
            end else if (r < 97) begin
               hold_left = $urandom_range(0, 2);
               rsp_if.ready <= 1'b0;
            end else begin
               hold_left = $urandom_range(20, 60);
               rsp_if.ready <= 1'b0;
            end
         end
      end
   end

   // Offer one byte after an optional random gap, return once it is taken
   task automatic send_byte(logic [dwmf_pkg::ByteWidth-1:0] b);
      int unsigned r;
      int unsigned gap;
      gap = 0;
      if (!steady) begin
         r = $urandom_range(0, 99);
         if (r >= 97) gap = $urandom_range(10, 40);
         else if (r >= 75) gap = $urandom_range(1, 3);
      end
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.data_byte <= b;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      sb.note_byte(b);
   endtask

   // Stop offering, drain expected results, let the pipeline settle
   task automatic finish_phase();
      req_if.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_window(logic [dwmf_pkg::WinLenWidth-1:0] v);
      csr_we    <= 1'b1;
      csr_wdata <= v;
      sb.set_window(v);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // One line: mostly bytes from a small distinct alphabet, sometimes noise
   task automatic send_line(int unsigned w_eff, bit cut_short);
      logic [dwmf_pkg::ByteWidth-1:0] alpha [24];
      bit   [255:0]                   used;
      logic [dwmf_pkg::ByteWidth-1:0] b;
      int unsigned                    a_size;
      int unsigned                    len;
      int unsigned                    k;
      int unsigned                    r;
      r = $urandom_range(0, 99);
      if (r < 12) begin
         len = $urandom_range(1, 30);
         for (k = 0; k < len; k++) send_byte(dwmf_pkg::ByteWidth'($urandom_range(0, 255)));
         return;
      end
      if (r < 35) a_size = $urandom_range(1, w_eff + 1);
      else a_size = $urandom_range(w_eff, w_eff + 8);
      if (a_size > 24) a_size = 24;
      used = '0;
      k = 0;
      while (k < a_size) begin
         b = dwmf_pkg::ByteWidth'($urandom_range(1, 255));
         if (b != dwmf_pkg::TermNewline && !used[b]) begin
            used[b]  = 1'b1;
            alpha[k] = b;
            k++;
         end
      end
      len = $urandom_range(1, 2 * w_eff + 12);
      for (k = 0; k < len; k++) send_byte(alpha[$urandom_range(0, a_size - 1)]);
      if (!cut_short) begin
         r = $urandom_range(0, 9);
         if (r < 5) send_byte(dwmf_pkg::TermNewline);
         else if (r < 9) send_byte(dwmf_pkg::TermNul);
      end
   endtask

   initial begin
      logic [dwmf_pkg::ByteWidth-1:0]   warmup [23];
      logic [dwmf_pkg::WinLenWidth-1:0] w;
      int unsigned                      win_list [8];
      int unsigned                      base;
      int unsigned                      phase_base;
      int unsigned                      phase;
      int unsigned                      k;

      warmup = '{8'h61, 8'h62, 8'h63, 8'h64,                      // found at 4
                 8'h78, dwmf_pkg::TermNewline,                    // skipped, quiet end
                 dwmf_pkg::TermNewline, dwmf_pkg::TermNul,        // empty lines fail
                 8'h61, 8'h62, 8'h61, 8'h63, 8'h64,               // repeat, found at 5
                 dwmf_pkg::TermNul,
                 8'hFF, 8'h01, 8'h80, 8'h7F,                      // extreme bytes
                 dwmf_pkg::TermNewline,
                 8'h61, 8'h61, 8'h61, dwmf_pkg::TermNewline};     // no marker
      win_list = '{1, 16, 0, 31, 17, 2, 4, 8};

      sb = new();
      steady = 1'b0;
      reset            <= 1'b1;
      req_if.valid     <= 1'b0;
      req_if.data_byte <= '0;
      csr_we           <= 1'b0;
      csr_wdata        <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed items at the reset window length
      for (k = 0; k < 23; k++) send_byte(warmup[k]);
      finish_phase();

      // Random phases; a phase may end mid-line so the next window applies mid-line
      base  = sb.taken;
      phase = 0;
      while (sb.taken - base < 550) begin
         w = (phase < 8) ? dwmf_pkg::WinLenWidth'(win_list[phase])
                         : dwmf_pkg::WinLenWidth'($urandom_range(0, 31));
         write_window(w);
         steady = ($urandom_range(0, 4) == 0);
         phase_base = sb.taken;
         do begin
            send_line(sb.effective_window(), 1'b0);
         end while (sb.taken - phase_base < 40);
         send_line(sb.effective_window(), 1'($urandom_range(0, 1)));
         finish_phase();
         phase++;
      end
      steady = 1'b0;

      // Overrun: two-byte alternation never reaches a 16-byte window
      write_window(dwmf_pkg::WinLenWidth'(16));
      send_byte(dwmf_pkg::TermNul);
      for (k = 0; k <= dwmf_pkg::MaxLine; k++) send_byte((k % 2) ? 8'h62 : 8'h61);
      send_byte(8'h63);
      send_byte(8'h64);
      send_byte(dwmf_pkg::TermNewline);
      finish_phase();

      // Marker completed by the last byte a line may hold
      write_window(dwmf_pkg::WinLenWidth'(2));
      for (k = 0; k < dwmf_pkg::MaxLine - 1; k++) send_byte(8'h61);
      send_byte(8'h62);
      send_byte(dwmf_pkg::TermNewline);
      finish_phase();

      repeat (10) @(posedge clock);
      if (sb.pending() != 0) begin
         $display("%0t: %0d expected result items never arrived", $time, sb.pending());
         sb.errors++;
      end
      if (sb.errors == 0) begin
         $display("distinct_window_marker_finder_core verification clean");
      end else begin
         $display("distinct_window_marker_finder_core verification failed");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
design/dwmf_pkg.sv
design/dwmf_req_if.sv
design/dwmf_rsp_if.sv
design/dwmf_datapath.sv
design/dwmf_ctrl.sv
design/distinct_window_marker_finder_core.sv
test/tb_distinct_window_marker_finder_core.sv
